FILE: sv/medss_pkg.sv
// ----------------------------------------------------------------------------
// Median of sample set: shared package
// Word types, field widths and the control structs passed between the top
// level and the sort engine.
// ----------------------------------------------------------------------------
package medss_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int MEDIAN_W        = 33;
    localparam int COUNT_OUT_W     = 9;
    localparam int MAX_SAMPLES_DEF = 256;

    // one input word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_times_two;
        logic [COUNT_OUT_W-1:0]     sample_count;
        logic                       overflow;
    } out_word_t;

    // top level -> engine
    typedef struct packed {
        logic start;     // input word accepted this cycle
        logic out_free;  // output register can take a result this cycle
    } eng_cmd_t;

    // engine -> top level
    typedef struct packed {
        logic ready;     // engine idle, can take a word
        logic done;      // result word presented
    } eng_status_t;

endpackage

FILE: sv/medss_engine.sv
// ----------------------------------------------------------------------------
// Median of sample set: sort engine
// Sorted sample store with one compare/shift step per cycle for insertion,
// then a median pass of one read (odd count) or two reads (even count) through a shared adder.
// ----------------------------------------------------------------------------
module medss_engine
    import medss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  eng_cmd_t    cmd,
    input  in_word_t    word,
    output eng_status_t status,
    output out_word_t   result
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT0,
        ST_MED_A,
        ST_MED_B,
        ST_MED_C,
        ST_HOLD
    } state_t;

    // sample store
    logic signed [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       dropped_reg, dropped_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] s_reg, s_next;
    logic                       last_reg, last_next;
    logic signed [MEDIAN_W-1:0] acc_reg, acc_next;

    logic [AW-1:0]              half;
    logic                       cnt_odd;
    logic signed [MEDIAN_W-1:0] rd_ext;
    logic signed [MEDIAN_W-1:0] add_a, add_b, add_sum;
    logic [CW+COUNT_OUT_W-1:0]  count_wide;

    assign half    = AW'(count_reg >> 1);
    assign cnt_odd = count_reg[0];
    assign rd_ext  = MEDIAN_W'(rd_data_reg);
    assign add_sum = add_a + add_b;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pos_next     = pos_reg;
        s_next       = s_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        rd_addr      = pos_reg - AW'(1);
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = s_reg;
        add_a        = acc_reg;
        add_b        = rd_ext;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    s_next    = word.sample;
                    last_next = word.last_sample;
                    if (count_reg == CNT_MAX)
                    begin
                        dropped_next = 1'b1;
                        state_next   = word.last_sample ? ST_MED_A : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = word.sample;
                        count_next = count_reg + CW'(1);
                        state_next = word.last_sample ? ST_MED_A : ST_IDLE;
                    end
                    else
                    begin
                        // read the current top entry, walk down from there
                        pos_next   = AW'(count_reg);
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (rd_data_reg > s_reg)
                begin
                    // shift the larger entry up one place
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - AW'(1);
                    rd_addr  = pos_reg - AW'(2);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = ST_PUT0;
                    end
                end
                else
                begin
                    wr_data    = s_reg;
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? ST_MED_A : ST_IDLE;
                end
            end

            ST_PUT0:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = s_reg;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? ST_MED_A : ST_IDLE;
            end

            ST_MED_A:
            begin
                rd_addr    = cnt_odd ? half : half - AW'(1);
                state_next = ST_MED_B;
            end

            ST_MED_B:
            begin
                if (cnt_odd)
                begin
                    add_a      = rd_ext;
                    add_b      = rd_ext;
                    acc_next   = add_sum;
                    state_next = ST_HOLD;
                end
                else
                begin
                    acc_next   = rd_ext;
                    rd_addr    = half;
                    state_next = ST_MED_C;
                end
            end

            ST_MED_C:
            begin
                acc_next   = add_sum;
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                if (cmd.out_free)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            pos_reg     <= '0;
            s_reg       <= '0;
            last_reg    <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            pos_reg     <= pos_next;
            s_reg       <= s_next;
            last_reg    <= last_next;
            acc_reg     <= acc_next;
        end
    end

    // count reported modulo 2^9
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};

    assign status.ready = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_HOLD);

    assign result.median_times_two = acc_reg;
    assign result.sample_count     = count_wide[COUNT_OUT_W-1:0];
    assign result.overflow         = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("kept count above capacity");

    a_hold_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> count_reg != '0)
        else $error("median given for an empty set");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == ST_IDLE)
        else $error("word started while engine busy");

    a_scan_growth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && state_next != ST_SCAN && state_next != ST_PUT0
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insertion did not add one entry");

endmodule

FILE: sv/median_of_sample_set_unit.sv
// ----------------------------------------------------------------------------
// Median of sample set: top level
// Accepts signed samples, keeps each set in ascending order and gives twice
// the median on the word marked last.
// ----------------------------------------------------------------------------
// Each accepted sample word is inserted into an ascending store of up to
// MAX_SAMPLES entries by a single compare-and-shift step that walks down from
// the top entry, one entry per cycle through the store's single read port.
// The walk stops above the first entry not greater than the new sample; a
// new smallest sample is written to the bottom entry in a step of its own.
// The first sample of a set and a sample dropped because the store is full
// need no walk. The word marked last then takes one median read (odd count)
// or two (even count) through the shared adder; the result word is placed in
// the output register. sample_stall stays high while a word is being worked
// on. A pending result does not block the next sample; only a second result
// waits until the first has been taken. The result gives twice the median
// exactly (sum of the two middle entries for an even count), the number of
// samples kept, and a flag set when samples beyond capacity were dropped; the
// set then restarts empty. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module median_of_sample_set_unit
    import medss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  in_word_t  sample_word,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result_word
);

    eng_cmd_t    cmd;
    eng_status_t status;
    out_word_t   eng_result;

    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg;

    // input side: take a word only while the engine is idle
    assign sample_stall = !status.ready;
    assign cmd.start    = sample_valid && status.ready;

    // output register is free when empty or being drained this cycle
    assign cmd.out_free = !out_valid_reg || !result_stall;

    medss_engine #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .word   (sample_word),
        .status (status),
        .result (eng_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done && cmd.out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (status.done && cmd.out_free)
        begin
            out_word_reg <= eng_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule
